/* rtl/cic_charge_deposit_2d_unit_defines.svh */
// ----------------------------------------------------------------------------
// cic charge deposit assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CIC_CHARGE_DEPOSIT_2D_UNIT_DEFINES_SVH
`define CIC_CHARGE_DEPOSIT_2D_UNIT_DEFINES_SVH

// same-cycle implication
`define CCD2D_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCD2D_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ccd2d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd2d package
// widths, codes and shared types of the cloud-in-cell charge deposit unit
// ----------------------------------------------------------------------------
package ccd2d_pkg;

    // default geometry
    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int POS_W     = 22;
    localparam int CI_W      = 12;
    localparam int CELL_W    = 48;
    localparam int CHG_W     = 32;
    localparam int BG_W      = 41;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = BG_W;

    localparam logic signed [CELL_W-1:0] CELL_MAX = {1'b0, {(CELL_W-1){1'b1}}};
    localparam logic signed [CELL_W-1:0] CELL_MIN = {1'b1, {(CELL_W-1){1'b0}}};

    localparam logic signed [CHG_W-1:0] CHARGE_RST = CHG_W'(65536);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_CHARGE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_LEVEL = CFG_IDX_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_DEPOSIT = 2'd1,
        OP_READ    = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_WRAP,
        ST_ISSUE,
        ST_DRAIN,
        ST_READ
    } state_t;

    // tag traveling with one corner update through the weight pipe
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

/* rtl/ccd2d_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd2d generic ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module ccd2d_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ccd2d_wrap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd2d index wrap
// two-stage reduction of the integer cell coordinates modulo the grid size
// ----------------------------------------------------------------------------
module ccd2d_wrap import ccd2d_pkg::*; #(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int INT_W     = POS_W - FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [INT_W-1:0]             x_int,
    input  logic [INT_W-1:0]             y_int,
    output logic                         done,
    output logic [$clog2(GRID_COLS)-1:0] x0,
    output logic [$clog2(GRID_COLS)-1:0] x1,
    output logic [$clog2(GRID_ROWS)-1:0] y0,
    output logic [$clog2(GRID_ROWS)-1:0] y1
);

    localparam int XW  = $clog2(GRID_COLS);
    localparam int YW  = $clog2(GRID_ROWS);
    // reciprocal scaling, quotient estimate is exact or one short
    localparam int XS  = INT_W + XW;
    localparam int YS  = INT_W + YW;
    localparam longint XM = (longint'(1) << XS) / GRID_COLS;
    localparam longint YM = (longint'(1) << YS) / GRID_ROWS;
    localparam int MW  = 2 * INT_W + 1;
    localparam int RXW = ((INT_W > XW) ? INT_W : XW) + 1;
    localparam int RYW = ((INT_W > YW) ? INT_W : YW) + 1;

    logic              v1_reg, v2_reg;
    logic [INT_W-1:0]  xi_reg, yi_reg;
    logic [INT_W-1:0]  xq_reg, xq_next;
    logic [INT_W-1:0]  yq_reg, yq_next;
    logic [XW-1:0]     rx_reg, rx_next;
    logic [YW-1:0]     ry_reg, ry_next;
    logic [MW-1:0]     px, py;
    logic [RXW-1:0]    dx;
    logic [RYW-1:0]    dy;

    // stage 1: quotient estimate by reciprocal multiply
    assign px      = MW'(x_int) * MW'(XM);
    assign py      = MW'(y_int) * MW'(YM);
    assign xq_next = INT_W'(px >> XS);
    assign yq_next = INT_W'(py >> YS);

    // stage 2: remainder, one correcting subtract
    always_comb
    begin
        dx = RXW'(xi_reg) - RXW'(xq_reg) * RXW'(GRID_COLS);
        dy = RYW'(yi_reg) - RYW'(yq_reg) * RYW'(GRID_ROWS);
        if (dx >= RXW'(GRID_COLS))
        begin
            dx = dx - RXW'(GRID_COLS);
        end
        if (dy >= RYW'(GRID_ROWS))
        begin
            dy = dy - RYW'(GRID_ROWS);
        end
        rx_next = XW'(dx);
        ry_next = YW'(dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            xi_reg <= x_int;
            yi_reg <= y_int;
            xq_reg <= xq_next;
            yq_reg <= yq_next;
        end
        if (v1_reg)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
    end

    assign done = v2_reg;
    assign x0   = rx_reg;
    assign y0   = ry_reg;
    assign x1   = (rx_reg == XW'(GRID_COLS - 1)) ? '0 : rx_reg + XW'(1);
    assign y1   = (ry_reg == YW'(GRID_ROWS - 1)) ? '0 : ry_reg + YW'(1);

endmodule

/* rtl/ccd2d_weight.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd2d weight pipe
// three-stage floor(charge * wx * wy / 2^(2F)), carrying the cell address
// ----------------------------------------------------------------------------
module ccd2d_weight import ccd2d_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int AW        = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tag_t                    in_tag,
    input  logic [AW-1:0]           in_addr,
    input  logic signed [CHG_W-1:0] charge,
    input  logic [FRAC_BITS:0]      wx,
    input  logic [FRAC_BITS:0]      wy,
    output tag_t                    rd_tag,
    output logic [AW-1:0]           rd_addr,
    output tag_t                    out_tag,
    output logic [AW-1:0]           out_addr,
    output logic signed [CHG_W:0]   weight
);

    localparam int PW  = CHG_W + FRAC_BITS + 1;
    localparam int PHW = PW - FRAC_BITS;
    localparam int LPW = 2 * FRAC_BITS + 1;
    localparam int SW  = PW + 1;

    tag_t                    t1_reg, t2_reg, t3_reg;
    logic [AW-1:0]           a1_reg, a2_reg, a3_reg;
    logic [FRAC_BITS:0]      wy1_reg;
    logic signed [PW-1:0]    p_next, p_reg;
    logic signed [PHW-1:0]   ph;
    logic [LPW-1:0]          lo_prod;
    logic signed [PW-1:0]    hi_next, hi_reg;
    logic [FRAC_BITS:0]      lo_reg;
    logic signed [SW-1:0]    s;
    logic signed [CHG_W:0]   w_next, w_reg;

    // stage 1: charge times x weight
    assign p_next  = $signed(charge) * $signed({1'b0, wx});
    // stage 2: split into high part and fraction, both times y weight
    assign ph      = PHW'(p_reg >>> FRAC_BITS);
    assign hi_next = ph * $signed({1'b0, wy1_reg});
    assign lo_prod = LPW'(p_reg[FRAC_BITS-1:0]) * LPW'(wy1_reg);
    // stage 3: recombine and floor
    assign s       = SW'(hi_reg) + SW'($signed({1'b0, lo_reg}));
    assign w_next  = (CHG_W+1)'(s >>> FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
        end
        else
        begin
            t1_reg <= in_tag;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg  <= in_addr;
        a2_reg  <= a1_reg;
        a3_reg  <= a2_reg;
        wy1_reg <= wy;
        p_reg   <= p_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_prod[2*FRAC_BITS:FRAC_BITS];
        w_reg   <= w_next;
    end

    assign rd_tag   = t2_reg;
    assign rd_addr  = a2_reg;
    assign out_tag  = t3_reg;
    assign out_addr = a3_reg;
    assign weight   = w_reg;

endmodule

/* rtl/cic_charge_deposit_2d_unit.sv */
`timescale 1ns / 1ps
`include "cic_charge_deposit_2d_unit_defines.svh"
// ----------------------------------------------------------------------------
// cloud-in-cell charge deposit unit
// scatters particle charge onto a periodic 2d grid held in one ram
// ----------------------------------------------------------------------------
// The grid of GRID_COLS x GRID_ROWS signed 48-bit cells sits in one ram with
// a write port and a registered read port, and the unit handles one request
// at a time. After reset the unit zeroes the grid in a clearing pass of one
// cell per cycle and takes no request until it finishes; configuration
// writes are taken at any time, cfg_ready is always high. A clear request
// runs the same pass with the background level. In a deposit request the
// cell coordinates are reduced modulo the grid size by a reciprocal multiply
// and one correcting subtract, then the four corners stream through a
// three-stage weight multiplier, and each corner is read, added with
// saturation and written back, one corner per cycle on the single ram write
// port. The next request waits until the last corner is written back, so no
// read can meet a pending write. A read request lands in an output register;
// a new request is taken while that result still waits for out_ready, only
// a second read stalls until the register drains. Cells beyond the grid read
// as zero.
// ----------------------------------------------------------------------------
module cic_charge_deposit_2d_unit import ccd2d_pkg::*; #(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [OP_W-1:0]             opcode,
    input  logic [POS_W-1:0]            x_pos,
    input  logic [POS_W-1:0]            y_pos,
    input  logic [CI_W-1:0]             cell_index,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [CELL_W-1:0]    cell_value,
    // configuration channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data
);

    localparam int NCELLS = GRID_COLS * GRID_ROWS;
    localparam int AW     = $clog2(NCELLS);
    localparam int XW     = $clog2(GRID_COLS);
    localparam int YW     = $clog2(GRID_ROWS);
    // integer part of a position, at least one bit wide
    localparam int INT_W  = (POS_W > FRAC_BITS) ? POS_W - FRAC_BITS : 1;
    localparam logic [FRAC_BITS:0] W_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // fsm
    state_t state_reg, state_next;
    logic   in_accept;
    logic   sweep_active;
    logic   issue_active;
    logic   read_load;
    opcode_t op;

    // configuration registers
    logic signed [CHG_W-1:0]  charge_cfg_reg, charge_cfg_next;
    logic signed [BG_W-1:0]   bg_cfg_reg, bg_cfg_next;

    // clearing pass
    logic [AW-1:0]            sweep_cnt_reg, sweep_cnt_next;
    logic signed [CELL_W-1:0] fill_reg, fill_next;
    logic                     sweep_last;

    // deposit item
    logic signed [CHG_W-1:0]  chg_reg;
    logic [FRAC_BITS-1:0]     fx_reg, fy_reg;
    logic [XW-1:0]            x0_reg, x1_reg;
    logic [AW-1:0]            row0_reg, row1_reg;
    logic [1:0]               corner_reg, corner_next;

    // wrap unit
    logic                     wrap_done;
    logic [XW-1:0]            wr_x0, wr_x1;
    logic [YW-1:0]            wr_y0, wr_y1;

    // weight pipe
    tag_t                     wp_in_tag, wp_rd_tag, wp_out_tag;
    logic [AW-1:0]            wp_in_addr, wp_rd_addr, wp_out_addr;
    logic [FRAC_BITS:0]       wp_wx, wp_wy;
    logic signed [CHG_W:0]    wp_weight;

    // ram
    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [CELL_W-1:0]        ram_wdata, ram_rdata;
    logic signed [CELL_W:0]   sum;
    logic signed [CELL_W-1:0] sat_sum;

    // result register
    logic                     rd_ok_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [CELL_W-1:0] out_data_reg;

    assign op        = opcode_t'(opcode);
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign sweep_last = (sweep_cnt_reg == AW'(NCELLS - 1));

    // ------------------------------------------------------------------
    // fsm next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (op)
                        OP_CLEAR:   state_next = ST_SWEEP;
                        OP_DEPOSIT: state_next = ST_WRAP;
                        OP_READ:    state_next = ST_READ;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRAP:
            begin
                if (wrap_done)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (corner_reg == 2'd3)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // leave as the last corner is written back
                if (wp_out_tag.valid && wp_out_tag.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (read_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // fsm outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready     = 1'b0;
        sweep_active = 1'b0;
        issue_active = 1'b0;
        read_load    = 1'b0;
        unique case (state_reg)
            ST_SWEEP: sweep_active = 1'b1;
            ST_IDLE:  in_ready     = 1'b1;
            ST_ISSUE: issue_active = 1'b1;
            ST_READ:  read_load    = !out_valid_reg || out_ready;
            ST_WRAP, ST_DRAIN:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // configuration decode
    // ------------------------------------------------------------------
    always_comb
    begin
        charge_cfg_next = charge_cfg_reg;
        bg_cfg_next     = bg_cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PARTICLE_CHARGE:  charge_cfg_next = $signed(cfg_data[CHG_W-1:0]);
                CFG_BACKGROUND_LEVEL: bg_cfg_next     = $signed(cfg_data[BG_W-1:0]);
                default:              charge_cfg_next = charge_cfg_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // control register next values
    // ------------------------------------------------------------------
    always_comb
    begin
        sweep_cnt_next = sweep_cnt_reg;
        fill_next      = fill_reg;
        corner_next    = corner_reg;
        out_valid_next = out_valid_reg;
        if (sweep_active)
        begin
            sweep_cnt_next = sweep_cnt_reg + AW'(1);
        end
        if (in_accept && op == OP_CLEAR)
        begin
            // background level held for the whole pass
            sweep_cnt_next = '0;
            fill_next      = CELL_W'(bg_cfg_reg);
        end
        if (wrap_done)
        begin
            corner_next = 2'd0;
        end
        else if (issue_active)
        begin
            corner_next = corner_reg + 2'd1;
        end
        if (read_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            charge_cfg_reg <= CHARGE_RST;
            bg_cfg_reg     <= '0;
            sweep_cnt_reg  <= '0;
            fill_reg       <= '0;
            corner_reg     <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            charge_cfg_reg <= charge_cfg_next;
            bg_cfg_reg     <= bg_cfg_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            fill_reg       <= fill_next;
            corner_reg     <= corner_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // item payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept && op == OP_DEPOSIT)
        begin
            // charge is taken per particle
            chg_reg <= charge_cfg_reg;
            fx_reg  <= FRAC_BITS'(x_pos);
            fy_reg  <= FRAC_BITS'(y_pos);
        end
        if (in_accept && op == OP_READ)
        begin
            rd_ok_reg <= (32'(cell_index) < 32'(NCELLS));
        end
        if (wrap_done)
        begin
            // row bases of both y corners, constant multiply
            x0_reg   <= wr_x0;
            x1_reg   <= wr_x1;
            row0_reg <= AW'(AW'(wr_y0) * AW'(GRID_COLS));
            row1_reg <= AW'(AW'(wr_y1) * AW'(GRID_COLS));
        end
        if (read_load)
        begin
            out_data_reg <= rd_ok_reg ? $signed(ram_rdata) : '0;
        end
    end

    // ------------------------------------------------------------------
    // coordinate wrap
    // ------------------------------------------------------------------
    ccd2d_wrap #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS),
        .INT_W     (INT_W)
    ) u_wrap (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_accept && op == OP_DEPOSIT),
        .x_int (INT_W'(x_pos >> FRAC_BITS)),
        .y_int (INT_W'(y_pos >> FRAC_BITS)),
        .done  (wrap_done),
        .x0    (wr_x0),
        .x1    (wr_x1),
        .y0    (wr_y0),
        .y1    (wr_y1)
    );

    // ------------------------------------------------------------------
    // corner issue: order (x0,y0) (x1,y0) (x0,y1) (x1,y1)
    // ------------------------------------------------------------------
    always_comb
    begin
        wp_in_tag.valid = issue_active;
        wp_in_tag.last  = (corner_reg == 2'd3);
        wp_wx           = corner_reg[0] ? {1'b0, fx_reg} : W_ONE - {1'b0, fx_reg};
        wp_wy           = corner_reg[1] ? {1'b0, fy_reg} : W_ONE - {1'b0, fy_reg};
        wp_in_addr      = (corner_reg[1] ? row1_reg : row0_reg)
                        + AW'(corner_reg[0] ? x1_reg : x0_reg);
    end

    ccd2d_weight #(
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW)
    ) u_weight (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (wp_in_tag),
        .in_addr  (wp_in_addr),
        .charge   (chg_reg),
        .wx       (wp_wx),
        .wy       (wp_wy),
        .rd_tag   (wp_rd_tag),
        .rd_addr  (wp_rd_addr),
        .out_tag  (wp_out_tag),
        .out_addr (wp_out_addr),
        .weight   (wp_weight)
    );

    // ------------------------------------------------------------------
    // read-modify-write: read one stage ahead, add and saturate on write
    // ------------------------------------------------------------------
    assign sum = (CELL_W+1)'($signed(ram_rdata)) + (CELL_W+1)'(wp_weight);

    always_comb
    begin
        if (sum[CELL_W] != sum[CELL_W-1])
        begin
            sat_sum = sum[CELL_W] ? CELL_MIN : CELL_MAX;
        end
        else
        begin
            sat_sum = sum[CELL_W-1:0];
        end
    end

    always_comb
    begin
        if (sweep_active)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_cnt_reg;
            ram_wdata = fill_reg;
        end
        else
        begin
            ram_we    = wp_out_tag.valid;
            ram_waddr = wp_out_addr;
            ram_wdata = sat_sum;
        end
        // a read request addresses the ram straight from the port
        if (in_ready)
        begin
            ram_re    = in_accept && op == OP_READ;
            ram_raddr = AW'(cell_index);
        end
        else
        begin
            ram_re    = wp_rd_tag.valid;
            ram_raddr = wp_rd_addr;
        end
    end

    ccd2d_ram #(
        .WIDTH (CELL_W),
        .DEPTH (NCELLS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign cell_value = out_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `CCD2D_ASSERT_IMP(a_no_rw_collide, ram_we && ram_re, ram_waddr != ram_raddr,
        "ram read meets a write to the same cell")
    `CCD2D_ASSERT_IMP(a_idle_no_write, in_ready, !ram_we,
        "grid written while requests are taken")
    `CCD2D_ASSERT_IMP(a_wrap_in_state, wrap_done, state_reg == ST_WRAP,
        "index wrap finished outside its wait state")
    `CCD2D_ASSERT_NXT(a_result_loaded, read_load, out_valid_reg,
        "read result not presented after load")

endmodule
